### hdl/rmp_pkg.sv
// shared types, sizes and command codes for the running median pairs unit
package rmp_pkg;

  localparam int unsigned STORE_DEPTH = 1024;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CNT_W       = $clog2(STORE_DEPTH + 1);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  // input transaction kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_PAIR  = 1'b1;

  // chain commands
  localparam logic [1:0] CMD_HOLD   = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_POP    = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  // command plus broadcast value for one sorted chain
  typedef struct packed {
    logic [1:0] cmd;
    data_t      value;
  } chain_ctrl_t;

endpackage

### hdl/rmp_cell.sv
// one cell of a sorted chain: holds one value, shifts on insert or pop
module rmp_cell (
  input  logic                clk_i,
  input  rmp_pkg::chain_ctrl_t ctrl_i,
  input  logic                is_max_i,
  input  logic                valid_i,
  input  rmp_pkg::data_t      prev_value_i,
  input  logic                prev_above_i,
  input  rmp_pkg::data_t      next_value_i,
  output rmp_pkg::data_t      value_o,
  output logic                above_o
);
  import rmp_pkg::*;

  data_t val_q, val_d;

  // new value belongs in front of this cell (empty cells always yield)
  always_comb begin
    if (is_max_i) begin
      above_o = !valid_i || (ctrl_i.value > val_q);
    end else begin
      above_o = !valid_i || (ctrl_i.value < val_q);
    end
  end

  // insert shifts down from the neighbor, pop shifts up
  always_comb begin
    val_d = val_q;
    case (ctrl_i.cmd)
      CMD_INSERT: begin
        if (above_o) begin
          val_d = prev_above_i ? prev_value_i : ctrl_i.value;
        end
      end
      CMD_POP: begin
        val_d = next_value_i;
      end
      default: begin
        val_d = val_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign value_o = val_q;

endmodule

### hdl/rmp_chain.sv
// sorted chain of cells with its fill count; top of the store sits in cell 0
module rmp_chain (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 is_max_i,
  input  rmp_pkg::chain_ctrl_t ctrl_i,
  output rmp_pkg::data_t       top_o,
  output rmp_pkg::cnt_t        count_o
);
  import rmp_pkg::*;

  data_t vals [STORE_DEPTH];
  logic  abv  [STORE_DEPTH];
  cnt_t  cnt_q, cnt_d;

  // row of cells wired to neighbors; cell 0 takes the broadcast value instead
  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
    data_t prev_v, next_v;
    logic  prev_a, vld;

    assign vld = CNT_W'(i) < cnt_q;

    if (i == 0) begin : g_first
      assign prev_v = ctrl_i.value;
      assign prev_a = 1'b0;
    end else begin : g_mid
      assign prev_v = vals[i-1];
      assign prev_a = abv[i-1];
    end

    if (i == STORE_DEPTH - 1) begin : g_last
      assign next_v = vals[i];
    end else begin : g_notlast
      assign next_v = vals[i+1];
    end

    rmp_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl_i),
      .is_max_i    (is_max_i),
      .valid_i     (vld),
      .prev_value_i(prev_v),
      .prev_above_i(prev_a),
      .next_value_i(next_v),
      .value_o     (vals[i]),
      .above_o     (abv[i])
    );
  end

  // fill count
  always_comb begin
    cnt_d = cnt_q;
    case (ctrl_i.cmd)
      CMD_INSERT: cnt_d = cnt_q + CNT_W'(1);
      CMD_POP:    cnt_d = cnt_q - CNT_W'(1);
      CMD_CLEAR:  cnt_d = '0;
      default:    cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign top_o   = vals[0];
  assign count_o = cnt_q;

endmodule

### hdl/running_median_pairs_unit.sv
// top level of the running median pairs unit: sequencer, leader and two chains
//
// Input channel (in_valid_i / in_ready_o) carries kind_i, first_value_i and
// second_value_i. A start transaction (kind 0) loads the leader from
// first_value_i, empties both stores and gives no result.
// A pair transaction (kind 1) inserts first_value_i, then second_value_i, into
// the lower (descending) or upper (ascending) chain, then rebalances by
// pushing the leader into the smaller chain and popping the larger one.
// Each chain step has its own state, so a pair steps through accept, the two
// inserts and the rebalance, and its result appears on the output channel
// (out_valid_o / out_ready_i) in the cycle after the rebalance.
// A pair that would overfill a store leaves all state alone, goes straight
// from accept to the rebalance step and returns the leader with overflow_o set.
// The output register is separate: a new transaction is taken while a result
// waits; if the receiver stalls, the block waits in the rebalance step.
// Reset empties both stores and clears the leader; store contents need no
// clearing since only entries below the fill count are ever compared.
module running_median_pairs_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           kind_i,
  input  rmp_pkg::data_t first_value_i,
  input  rmp_pkg::data_t second_value_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rmp_pkg::data_t median_value_o,
  output logic           overflow_o
);
  import rmp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_INSA = 2'd1;
  localparam logic [1:0] S_INSB = 2'd2;
  localparam logic [1:0] S_BAL  = 2'd3;

  logic [1:0]  state_q, state_d;
  data_t       leader_q, leader_d;
  data_t       a_q, b_q;
  logic        ovf_q, ovf_d;
  logic        out_valid_q, out_valid_d;
  data_t       median_q, median_d;
  logic        oflag_q, oflag_d;
  chain_ctrl_t lo_ctrl, up_ctrl;
  data_t       lo_top, up_top;
  cnt_t        lo_cnt, up_cnt;
  logic        in_fire, out_free, full;
  data_t       ins_v;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // a store must have room for two more values
  assign full = ({1'b0, lo_cnt} + (CNT_W+1)'(2) > (CNT_W+1)'(STORE_DEPTH)) ||
                ({1'b0, up_cnt} + (CNT_W+1)'(2) > (CNT_W+1)'(STORE_DEPTH));

  assign ins_v = (state_q == S_INSA) ? a_q : b_q;

  // sequencer
  always_comb begin
    state_d       = state_q;
    leader_d      = leader_q;
    ovf_d         = ovf_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    median_d      = median_q;
    oflag_d       = oflag_q;
    lo_ctrl.cmd   = CMD_HOLD;
    lo_ctrl.value = ins_v;
    up_ctrl.cmd   = CMD_HOLD;
    up_ctrl.value = ins_v;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (kind_i == KIND_START) begin
            leader_d    = first_value_i;
            lo_ctrl.cmd = CMD_CLEAR;
            up_ctrl.cmd = CMD_CLEAR;
          end else begin
            ovf_d   = full;
            state_d = full ? S_BAL : S_INSA;
          end
        end
      end
      S_INSA, S_INSB: begin
        if (ins_v < leader_q) begin
          lo_ctrl.cmd = CMD_INSERT;
        end else begin
          up_ctrl.cmd = CMD_INSERT;
        end
        state_d = (state_q == S_INSA) ? S_INSB : S_BAL;
      end
      S_BAL: begin
        if (out_free) begin
          if (!ovf_q) begin
            if (lo_cnt > up_cnt) begin
              up_ctrl.cmd   = CMD_INSERT;
              up_ctrl.value = leader_q;
              lo_ctrl.cmd   = CMD_POP;
              leader_d      = lo_top;
            end else if (lo_cnt < up_cnt) begin
              lo_ctrl.cmd   = CMD_INSERT;
              lo_ctrl.value = leader_q;
              up_ctrl.cmd   = CMD_POP;
              leader_d      = up_top;
            end
          end
          out_valid_d = 1'b1;
          median_d    = leader_d;
          oflag_d     = ovf_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      leader_q    <= '0;
      out_valid_q <= 1'b0;
      ovf_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      leader_q    <= leader_d;
      out_valid_q <= out_valid_d;
      ovf_q       <= ovf_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_q <= first_value_i;
      b_q <= second_value_i;
    end
    median_q <= median_d;
    oflag_q  <= oflag_d;
  end

  rmp_chain u_lower (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .is_max_i(1'b1),
    .ctrl_i  (lo_ctrl),
    .top_o   (lo_top),
    .count_o (lo_cnt)
  );

  rmp_chain u_upper (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .is_max_i(1'b0),
    .ctrl_i  (up_ctrl),
    .top_o   (up_top),
    .count_o (up_cnt)
  );

  assign out_valid_o    = out_valid_q;
  assign median_value_o = median_q;
  assign overflow_o     = oflag_q;

endmodule

### hdl/rmp_checker.sv
// port-level checks for the running median pairs unit, bound to the top level
module rmp_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           kind_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input rmp_pkg::data_t median_value_o,
  input logic           overflow_o
);
  import rmp_pkg::*;

  // a pair keeps the block busy in the next cycle
  a_pair_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && kind_i == KIND_PAIR |=> !in_ready_o)
    else $error("ready right after a pair transaction");

  // a start transaction never produces a result
  a_start_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && kind_i == KIND_START && !out_valid_o |=> !out_valid_o)
    else $error("result after a start transaction");

  // a new result appears only as the block returns to idle
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result while block still busy");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(median_value_o) && $stable(overflow_o))
    else $error("stalled result changed");

endmodule

bind running_median_pairs_unit rmp_checker u_rmp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .kind_i        (kind_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .median_value_o(median_value_o),
  .overflow_o    (overflow_o)
);
